[hw/rtl/spag_pkg.sv]
// Package for the sine phase accumulator generator: widths, register indexes, sine ROM builder.
package spag_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;

    localparam int QTR_LEN  = 1 << TABLE_ADDR_BITS;
    localparam int ROM_AW   = TABLE_ADDR_BITS + 1;
    localparam int MAG_W    = 16;
    localparam int AMP_W    = 15;
    localparam int TUNE_W   = 32;
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = AMP_W + MAG_W;
    localparam int CFG_DATA_W = TUNE_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TUNING_WORD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE   = 1'b1;

    localparam logic [TUNE_W-1:0] TUNING_WORD_RST = 32'd39370534;
    localparam logic [AMP_W-1:0]  AMPLITUDE_RST   = 15'd9830;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q15_MAX     = 64'd32767;

    // next odd power term, before the factorial step: term * x^2 in Q30
    function automatic logic [63:0] pow2_step(input logic [63:0] term, input logic [63:0] x);
        logic [63:0] t;
        begin
            t = (term * x) >> 30;
            t = (t * x) >> 30;
            return t;
        end
    endfunction

    function automatic logic [63:0] sub_floor(input logic [63:0] a, input logic [63:0] b);
        begin
            return (a >= b) ? (a - b) : 64'd0;
        end
    endfunction

    // quarter-wave sine entry k, Taylor series to x^15 in Q30, rounded to Q15
    function automatic logic [MAG_W-1:0] sine_rom_entry(input int unsigned k);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        begin
            x    = (HALF_PI_Q30 * 64'(k)) >> TABLE_ADDR_BITS;
            term = x;
            sum  = x;
            term = pow2_step(term, x) / 64'd6;
            sum  = sub_floor(sum, term);
            term = pow2_step(term, x) / 64'd20;
            sum  = sum + term;
            term = pow2_step(term, x) / 64'd42;
            sum  = sub_floor(sum, term);
            term = pow2_step(term, x) / 64'd72;
            sum  = sum + term;
            term = pow2_step(term, x) / 64'd110;
            sum  = sub_floor(sum, term);
            term = pow2_step(term, x) / 64'd156;
            sum  = sum + term;
            term = pow2_step(term, x) / 64'd210;
            sum  = sub_floor(sum, term);
            v    = (sum * Q15_MAX + (64'd1 << 29)) >> 30;
            if (v > Q15_MAX)
            begin
                v = Q15_MAX;
            end
            return v[MAG_W-1:0];
        end
    endfunction

endpackage

[hw/rtl/sine_phase_accumulator_generator.sv]
// Sine NCO top level: phase accumulator, synchronous quarter-wave ROM, gain and sign stages.
//
//  channel | signals                                   | role
//  req     | req_valid, req_stall, last_of_frame       | sample request beat in
//  smp     | smp_valid, smp_stall, sample, frame_last  | sample beat out
//  cfg     | cfg_we, cfg_index, cfg_data               | register write, no wait
//
// One beat per cycle sustained while smp_stall is low; registered stages are ROM read, multiply, round and sign.
// The ROM read port and the single gain multiplier each take one beat per cycle while the output is not stalled.
// Reset clears the phase, restores tuning word and amplitude, empties the pipeline.
// A stalled output beat freezes every stage, bubbles included, and raises req_stall.
module sine_phase_accumulator_generator
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic                               last_of_frame,
    output logic                               smp_valid,
    input  logic                               smp_stall,
    output logic signed [spag_pkg::SAMPLE_W-1:0] sample,
    output logic                               frame_last,
    input  logic                               cfg_we,
    input  logic [spag_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spag_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import spag_pkg::*;

    logic [MAG_W-1:0] rom_mem [0:QTR_LEN];

    logic [PHASE_BITS-1:0]  phase_acc_reg;
    logic [TUNE_W-1:0]      tuning_word_reg;
    logic [AMP_W-1:0]       amplitude_reg;

    logic                   s1_valid_reg;
    logic                   s1_neg_reg;
    logic                   s1_last_reg;
    logic [MAG_W-1:0]       rom_data_reg;

    logic                   s2_valid_reg;
    logic                   s2_neg_reg;
    logic                   s2_last_reg;
    logic [PROD_W-1:0]      prod_reg;

    logic                   out_valid_reg;
    logic [SAMPLE_W-1:0]    sample_reg;
    logic                   frame_last_reg;

    logic                   advance;
    logic                   accept;
    logic [1:0]             quad;
    logic [ROM_AW-1:0]      idx;
    logic [ROM_AW-1:0]      rom_addr;
    logic [PHASE_BITS-1:0]  phase_acc_next;
    logic [PROD_W:0]        rounded;
    logic [SAMPLE_W-1:0]    mag_q15;
    logic [SAMPLE_W-1:0]    sample_next;

    genvar k;
    generate
        for (k = 0; k <= QTR_LEN; k++)
        begin : g_rom
            localparam logic [MAG_W-1:0] ENTRY = sine_rom_entry(k);
            assign rom_mem[k] = ENTRY;
        end
    endgenerate

    assign advance   = !(out_valid_reg && smp_stall);
    assign accept    = req_valid && advance;
    assign req_stall = !advance;

    assign quad     = phase_acc_reg[PHASE_BITS-1 -: 2];
    assign idx      = {1'b0, phase_acc_reg[PHASE_BITS-3 -: TABLE_ADDR_BITS]};
    assign rom_addr = quad[0] ? (ROM_AW'(QTR_LEN) - idx) : idx;

    // phase width may differ from the tuning word width
    assign phase_acc_next = phase_acc_reg + PHASE_BITS'(tuning_word_reg);

    // round half away from zero on the magnitude, then apply the sign
    assign rounded     = {1'b0, prod_reg} + (PROD_W + 1)'(1 << 14);
    assign mag_q15     = rounded[15 +: SAMPLE_W];
    assign sample_next = s2_neg_reg ? (SAMPLE_W'(0) - mag_q15) : mag_q15;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tuning_word_reg <= TUNING_WORD_RST;
            amplitude_reg   <= AMPLITUDE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TUNING_WORD: tuning_word_reg <= cfg_data[TUNE_W-1:0];
                CFG_AMPLITUDE:   amplitude_reg   <= cfg_data[AMP_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (accept)
            begin
                phase_acc_reg <= phase_acc_next;
            end
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // ROM read and payload stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rom_data_reg   <= rom_mem[rom_addr];
            s1_neg_reg     <= quad[1];
            s1_last_reg    <= last_of_frame;
            prod_reg       <= PROD_W'(amplitude_reg) * PROD_W'(rom_data_reg);
            s2_neg_reg     <= s1_neg_reg;
            s2_last_reg    <= s1_last_reg;
            sample_reg     <= sample_next;
            frame_last_reg <= s2_last_reg;
        end
    end

    assign smp_valid  = out_valid_reg;
    assign sample     = sample_reg;
    assign frame_last = frame_last_reg;

endmodule

[tb/sine_phase_accumulator_generator_tb.sv]
// Self-checking testbench for the sine NCO: directed edge cases, random tones, random stalls.
`timescale 1ns / 100ps

module sine_phase_accumulator_generator_tb;
    import spag_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int TONE_PHASES  = 15;
    localparam int TONE_BEATS   = 70;

    typedef struct packed
    {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_last;
    } sample_beat_t;

    logic                         clk           = 1'b0;
    logic                         rst_n         = 1'b0;
    logic                         req_valid     = 1'b0;
    logic                         last_of_frame = 1'b0;
    logic                         smp_stall     = 1'b0;
    logic                         cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index     = CFG_TUNING_WORD;
    logic [CFG_DATA_W-1:0]        cfg_data      = '0;
    logic                         req_stall;
    logic                         smp_valid;
    logic signed [SAMPLE_W-1:0]   sample;
    logic                         frame_last;

    logic [MAG_W-1:0]      quarter_sine [0:QTR_LEN];
    logic [PHASE_BITS-1:0] phase_model = '0;
    logic [TUNE_W-1:0]     step_model  = TUNING_WORD_RST;
    logic [AMP_W-1:0]      gain_model  = AMPLITUDE_RST;
    sample_beat_t          pending_samples [$];

    int  mismatches    = 0;
    int  beats_checked = 0;
    int  requests_sent = 0;
    int  cfg_writes    = 0;
    int  stall_left    = 0;
    bit  steady        = 1'b0;

    sine_phase_accumulator_generator u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .last_of_frame (last_of_frame),
        .smp_valid     (smp_valid),
        .smp_stall     (smp_stall),
        .sample        (sample),
        .frame_last    (frame_last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("sine_phase_accumulator_generator_tb: done, errors");
        $finish;
    end

    function automatic logic [63:0] taylor_sine_q30(input logic [63:0] x);
        logic [63:0] term;
        logic [63:0] sum;
        int          n;
        term = x;
        sum  = x;
        for (n = 1; n <= 7; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
            begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end
            else
            begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic sample_beat_t predict_sample(input logic lof);
        logic [1:0]               quad;
        logic [TABLE_ADDR_BITS:0] addr;
        logic [31:0]              p;
        sample_beat_t             beat;
        quad = phase_model[PHASE_BITS-1 -: 2];
        addr = {1'b0, phase_model[PHASE_BITS-3 -: TABLE_ADDR_BITS]};
        if (quad[0])
        begin
            addr = (TABLE_ADDR_BITS + 1)'(QTR_LEN) - addr;
        end
        p = (32'(gain_model) * 32'(quarter_sine[addr]) + 32'd16384) >> 15;
        beat.sample     = quad[1] ? -p[SAMPLE_W-1:0] : p[SAMPLE_W-1:0];
        beat.frame_last = lof;
        return beat;
    endfunction

    task automatic send_request(input logic lof);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid     <= 1'b1;
        last_of_frame <= lof;
        do @(posedge clk); while (req_stall);
        pending_samples.push_back(predict_sample(lof));
        phase_model = phase_model + step_model;
        requests_sent++;
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic retune(input logic [TUNE_W-1:0] tune, input logic [CFG_DATA_W-1:0] gain_data);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TUNING_WORD;
        cfg_data  <= tune;
        @(posedge clk);
        step_model = tune;
        cfg_index <= CFG_AMPLITUDE;
        cfg_data  <= gain_data;
        @(posedge clk);
        gain_model = gain_data[AMP_W-1:0];
        cfg_we <= 1'b0;
        @(posedge clk);
        cfg_writes += 2;
    endtask

    always @(posedge clk)
    begin
        sample_beat_t want;
        if (rst_n && smp_valid && !smp_stall)
        begin
            if (pending_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected sample beat: sample %0d frame_last %0b",
                             sample, frame_last);
                end
            end
            else
            begin
                want = pending_samples.pop_front();
                beats_checked++;
                if (sample !== want.sample || frame_last !== want.frame_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("beat %0d: expected sample %0d last %0b, got sample %0d last %0b",
                                 beats_checked, want.sample, want.frame_last, sample, frame_last);
                    end
                end
            end
            stall_left = steady ? 0 : $urandom_range(0, 9);
        end
        if (stall_left > 0)
        begin
            smp_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            smp_stall <= 1'b0;
        end
    end

    // phase starts at zero with reset gain and step
    task automatic test_reset_state();
        int i;
        for (i = 0; i < 6; i++)
        begin
            send_request(i % 3 == 2);
        end
    endtask

    // quarter-turn step visits each quadrant in turn at full gain
    task automatic test_quadrant_edges();
        int i;
        retune(32'h4000_0000, 32'd32767);
        for (i = 0; i < 8; i++)
        begin
            send_request(i[0]);
        end
    endtask

    task automatic test_gain_extremes();
        int i;
        retune(32'hFFFF_FFFF, 32'd0);
        for (i = 0; i < 3; i++)
        begin
            send_request(1'b1);
        end
        // excess data bits above the gain field must be dropped
        retune(32'd0, {17'h1FFFF, 15'h7FFF});
        for (i = 0; i < 3; i++)
        begin
            send_request(1'b0);
        end
        retune(32'h0010_0000, 32'd1);
        for (i = 0; i < 4; i++)
        begin
            send_request(i == 3);
        end
    endtask

    task automatic test_random_tones();
        int                    ph;
        int                    i;
        int                    frame_left;
        logic [TUNE_W-1:0]     tune;
        logic [CFG_DATA_W-1:0] gain_data;
        for (ph = 0; ph < TONE_PHASES; ph++)
        begin
            case ($urandom_range(0, 5))
                0: tune = 32'd0;
                1: tune = 32'hFFFF_FFFF;
                2: tune = $urandom_range(1, 1 << 22);
                3: tune = 32'h8000_0000;
                default: tune = $urandom;
            endcase
            gain_data = $urandom;
            case ($urandom_range(0, 3))
                0: gain_data[AMP_W-1:0] = '0;
                1: gain_data[AMP_W-1:0] = '1;
                default: ;
            endcase
            steady = (ph % 4 == 3);
            retune(tune, gain_data);
            frame_left = $urandom_range(1, 24);
            for (i = 0; i < TONE_BEATS; i++)
            begin
                send_request(frame_left == 1);
                frame_left = (frame_left == 1) ? $urandom_range(1, 24) : frame_left - 1;
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        int          k;
        logic [63:0] x;
        logic [63:0] v;
        for (k = 0; k <= QTR_LEN; k++)
        begin
            x = (HALF_PI_Q30 * 64'(k)) >> TABLE_ADDR_BITS;
            v = (taylor_sine_q30(x) * Q15_MAX + (64'd1 << 29)) >> 30;
            quarter_sine[k] = (v > Q15_MAX) ? Q15_MAX[MAG_W-1:0] : v[MAG_W-1:0];
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_quadrant_edges();
        test_gain_extremes();
        test_random_tones();
        wait_idle();

        $display("%0d sample requests sent, %0d beats checked, %0d register writes",
                 requests_sent, beats_checked, cfg_writes);
        $display("covered quadrant edges, zero and full gain, extreme steps and random tones");
        if (mismatches == 0 && pending_samples.size() == 0)
        begin
            $display("sine_phase_accumulator_generator_tb: done, clean");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("sine_phase_accumulator_generator_tb: done, errors");
        end
        $finish;
    end

endmodule
